>>> rtl/q2e_pkg.sv
// shared types, constants and the arctangent table for the quaternion to euler block
`default_nettype none
package q2e_pkg;
	localparam int ARG_W = 35;
	localparam int CW = 38;
	localparam int ZW = 24;
	localparam int REM_W = 57;
	localparam int SQ_STEPS = 29;
	localparam int MAG_W = 28;
	localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [ARG_W-1:0] ONE_Q28 = 35'sd268435456;

	typedef struct packed {
		logic signed [ARG_W-1:0] sr;
		logic signed [ARG_W-1:0] cr;
		logic signed [ARG_W-1:0] sp;
		logic signed [ARG_W-1:0] sy;
		logic signed [ARG_W-1:0] cy;
		logic [REM_W-1:0] rem;
		logic clamp;
	} q2e_item_t;

	function automatic logic signed [ZW-1:0] atan_q20(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = 24'sd823550;
			1: a = 24'sd486170;
			2: a = 24'sd256879;
			3: a = 24'sd130396;
			4: a = 24'sd65451;
			5: a = 24'sd32757;
			6: a = 24'sd16383;
			7: a = 24'sd8192;
			8: a = 24'sd4096;
			9: a = 24'sd2048;
			10: a = 24'sd1024;
			11: a = 24'sd512;
			12: a = 24'sd256;
			13: a = 24'sd128;
			14: a = 24'sd64;
			15: a = 24'sd32;
			16: a = 24'sd16;
			17: a = 24'sd8;
			18: a = 24'sd4;
			19: a = 24'sd2;
			20: a = 24'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

>>> rtl/q2e_front.sv
// front pipeline: component products, product sums and pitch saturation check
`default_nettype none
module q2e_front
	import q2e_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_vld,
	output logic in_rdy,
	input wire logic signed [15:0] qw,
	input wire logic signed [15:0] qx,
	input wire logic signed [15:0] qy,
	input wire logic signed [15:0] qz,
	output logic out_vld,
	input wire logic out_rdy,
	output q2e_item_t out_item
);
	logic adv;
	logic v_s1, v_s2, v_s3;
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [ARG_W-1:0] sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;
	logic signed [ARG_W-1:0] sp_abs;
	logic [MAG_W-1:0] mag;
	logic [2*MAG_W-1:0] mag_sq;
	q2e_item_t item_s3;

	assign adv = !v_s3 || out_rdy;
	assign in_rdy = adv;

	assign sp_abs = sp_s2[ARG_W-1] ? -sp_s2 : sp_s2;
	assign mag = sp_abs[MAG_W-1:0];
	assign mag_sq = mag * mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
			sr_s2 <= (ARG_W'(wx_s1) + ARG_W'(yz_s1)) <<< 1;
			cr_s2 <= ONE_Q28 - ((ARG_W'(xx_s1) + ARG_W'(yy_s1)) <<< 1);
			sp_s2 <= (ARG_W'(wy_s1) - ARG_W'(zx_s1)) <<< 1;
			sy_s2 <= (ARG_W'(wz_s1) + ARG_W'(xy_s1)) <<< 1;
			cy_s2 <= ONE_Q28 - ((ARG_W'(yy_s1) + ARG_W'(zz_s1)) <<< 1);
			item_s3.sr <= sr_s2;
			item_s3.cr <= cr_s2;
			item_s3.sp <= sp_s2;
			item_s3.sy <= sy_s2;
			item_s3.cy <= cy_s2;
			item_s3.rem <= (REM_W'(1) << (2 * MAG_W)) - REM_W'(mag_sq);
			item_s3.clamp <= (sp_s2 >= ONE_Q28) || (sp_s2 <= -ONE_Q28);
		end
	end

	assign out_vld = v_s3;
	assign out_item = item_s3;
endmodule
`default_nettype wire

>>> rtl/q2e_queue.sv
// two entry queue between the front and back pipelines
`default_nettype none
module q2e_queue
	import q2e_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	output logic full,
	input wire q2e_item_t wr_item,
	input wire logic rd,
	output logic empty,
	output q2e_item_t rd_item
);
	q2e_item_t ent_q [0:1];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr_en, rd_en;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;
	assign rd_item = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en)
				wp_q <= !wp_q;
			if (rd_en)
				rp_q <= !rp_q;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 2'd1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			ent_q[wp_q] <= wr_item;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count not incremented");
	a_cnt_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !wr_en) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("queue count not decremented");
endmodule
`default_nettype wire

>>> rtl/q2e_cordic.sv
// pipelined vectoring cordic giving a clamped two argument arctangent
`default_nettype none
module q2e_cordic
	import q2e_pkg::*;
#(
	parameter int STEPS = 16,
	parameter logic signed [15:0] LIM = 16'sd25736
) (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [ARG_W-1:0] y_in,
	input wire logic signed [ARG_W-1:0] x_in,
	output logic signed [15:0] angle
);
	logic signed [CW-1:0] x_q [0:STEPS];
	logic signed [CW-1:0] y_q [0:STEPS];
	logic signed [ZW-1:0] z_q [0:STEPS];
	logic zf_q [0:STEPS];
	logic signed [CW-1:0] xe, ye;
	logic signed [ZW-1:0] zr;
	logic signed [15:0] angle_q;

	assign xe = CW'(x_in);
	assign ye = CW'(y_in);

	always_ff @(posedge clk) begin
		if (en) begin
			zf_q[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q[0] <= ye;
					y_q[0] <= -xe;
					z_q[0] <= HALF_PI_Q20;
				end else begin
					x_q[0] <= -ye;
					y_q[0] <= xe;
					z_q[0] <= -HALF_PI_Q20;
				end
			end else begin
				x_q[0] <= xe;
				y_q[0] <= ye;
				z_q[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				zf_q[i+1] <= zf_q[i];
				if (y_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_q20(i);
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_q20(i);
				end
			end
		end
	end

	assign zr = (z_q[STEPS] + ZW'(64)) >>> 7;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zf_q[STEPS])
				angle_q <= '0;
			else if (zr > ZW'(LIM))
				angle_q <= LIM;
			else if (zr < -ZW'(LIM))
				angle_q <= -LIM;
			else
				angle_q <= zr[15:0];
		end
	end

	assign angle = angle_q;
endmodule
`default_nettype wire

>>> rtl/q2e_back.sv
// back pipeline: square root for the pitch cosine, then three arctangent units
`default_nettype none
module q2e_back
	import q2e_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_vld,
	output logic in_rdy,
	input wire q2e_item_t in_item,
	output logic empty,
	input wire logic pop,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic pitch_clamped
);
	localparam int CDLY = CORDIC_STEPS + 2;
	localparam int NV = SQ_STEPS + 1 + CDLY;

	logic adv;
	logic [NV-1:0] vld_q;
	q2e_item_t it_q [0:SQ_STEPS];
	logic [REM_W:0] v_q [0:SQ_STEPS];
	logic [REM_W:0] r_q [0:SQ_STEPS];
	logic clamp_q [0:CDLY-1];
	logic neg_q [0:CDLY-1];
	logic signed [ARG_W-1:0] cos_p;
	logic signed [15:0] roll_c, pitch_c, yaw_c;

	assign adv = !vld_q[NV-1] || pop;
	assign in_rdy = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NV-2:0], in_vld};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_q[0] <= in_item;
			v_q[0] <= (REM_W + 1)'(in_item.rem);
			r_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		localparam logic [REM_W:0] BITV = (REM_W + 1)'(1) << (2 * (SQ_STEPS - 1 - k));
		always_ff @(posedge clk) begin
			if (adv) begin
				it_q[k+1] <= it_q[k];
				if (v_q[k] >= r_q[k] + BITV) begin
					v_q[k+1] <= v_q[k] - (r_q[k] + BITV);
					r_q[k+1] <= (r_q[k] >> 1) + BITV;
				end else begin
					v_q[k+1] <= v_q[k];
					r_q[k+1] <= r_q[k] >> 1;
				end
			end
		end
	end

	assign cos_p = ARG_W'(r_q[SQ_STEPS][SQ_STEPS-1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_q[0] <= it_q[SQ_STEPS].clamp;
			neg_q[0] <= it_q[SQ_STEPS].sp[ARG_W-1];
		end
	end

	for (genvar j = 1; j < CDLY; j++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				clamp_q[j] <= clamp_q[j-1];
				neg_q[j] <= neg_q[j-1];
			end
		end
	end

	q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_roll (
		.clk(clk), .en(adv),
		.y_in(it_q[SQ_STEPS].sr), .x_in(it_q[SQ_STEPS].cr), .angle(roll_c)
	);
	q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(HALF_PI_Q13)) u_pitch (
		.clk(clk), .en(adv),
		.y_in(it_q[SQ_STEPS].sp), .x_in(cos_p), .angle(pitch_c)
	);
	q2e_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_yaw (
		.clk(clk), .en(adv),
		.y_in(it_q[SQ_STEPS].sy), .x_in(it_q[SQ_STEPS].cy), .angle(yaw_c)
	);

	assign empty = !vld_q[NV-1];
	assign roll_angle = roll_c;
	assign yaw_angle = yaw_c;
	assign pitch_clamped = clamp_q[CDLY-1];
	assign pitch_angle = clamp_q[CDLY-1]
		? (neg_q[CDLY-1] ? -HALF_PI_Q13[14:0] : HALF_PI_Q13[14:0])
		: pitch_c[14:0];
endmodule
`default_nettype wire

>>> rtl/quaternion_to_euler_angles.sv
// top level: unit quaternion in, roll, pitch and yaw out
// Usage: input side is a queue write port (push, full, quat_*); a beat is taken
// at a clock edge with push high and full low. The result side is a queue read
// port (empty, pop, angles); the oldest result is shown while empty is low and
// is taken at an edge with pop high.
// Throughput: one beat per cycle when not stalled by pop, fully pipelined,
// no dependence between beats. Path: an input beat passes a three stage
// product front, the two entry queue, a 29 stage square root and the
// CORDIC_STEPS + 2 stage arctangent units working side by side.
// Reset: asynchronous, clears all valid flags; no results are pending after it.
// Stall: when pop stays low the back pipeline holds, the queue fills, then the
// front holds and full rises; no beat is lost or repeated.
// Angles are Q13 radians; pitch saturates at plus or minus pi/2 with
// pitch_clamped set.
`default_nettype none
module quaternion_to_euler_angles
	import q2e_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic signed [15:0] quat_w,
	input wire logic signed [15:0] quat_x,
	input wire logic signed [15:0] quat_y,
	input wire logic signed [15:0] quat_z,
	output logic empty,
	input wire logic pop,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic pitch_clamped
);
	logic fr_rdy, fr_vld, q_full, q_empty, bk_rdy;
	q2e_item_t fr_item, q_item;

	assign full = !fr_rdy;

	q2e_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_vld(push), .in_rdy(fr_rdy),
		.qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z),
		.out_vld(fr_vld), .out_rdy(!q_full), .out_item(fr_item)
	);

	q2e_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(fr_vld), .full(q_full), .wr_item(fr_item),
		.rd(bk_rdy), .empty(q_empty), .rd_item(q_item)
	);

	q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_vld(!q_empty), .in_rdy(bk_rdy), .in_item(q_item),
		.empty(empty), .pop(pop),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
	);
endmodule
`default_nettype wire
